>>> rtl/spiw_pkg.sv
// Shared widths, types and register codes for the segment pair intersection block.
// No dependencies; every other file in rtl imports it.
package spiw_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 32;
  localparam int DIF_W      = COORD_BITS + 1;         // endpoint differences
  localparam int CW         = 2 * COORD_BITS + 2;     // line constants and determinant
  localparam int NW         = CW + DIF_W + 1;         // Cramer numerators
  localparam int QB         = COORD_BITS + FRAC_BITS; // quotient bits
  localparam int DSTEPS     = 4;                      // quotient bits per divider stage
  localparam int DSTAGES    = QB / DSTEPS;
  localparam int NRNG       = 6;                      // x: A, B, window; y: A, B, window
  localparam int CFG_IDX_W  = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OUT_BITS-1:0]   out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C1X,
    REG_C1Y,
    REG_C2X,
    REG_C2Y
  } cfg_reg_t;

  typedef struct packed {
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
  } win_t;

  typedef struct packed {
    logic            v;
    logic            hit;
    logic            negx;
    logic            negy;
    logic [CW-1:0]   dabs;
    logic [CW-1:0]   remx;
    logic [CW-1:0]   remy;
    logic [QB-1:0]   dqx;
    logic [QB-1:0]   dqy;
  } dstage_t;

endpackage

>>> rtl/spiw_geom.sv
// Front pipeline: line equations, determinant, Cramer numerators and exact bounds tests.
// Seven register stages; hands the divider its dividends. Depends on spiw_pkg.
module spiw_geom (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  spiw_pkg::coord_t seg_a_start_x,
  input  spiw_pkg::coord_t seg_a_start_y,
  input  spiw_pkg::coord_t seg_a_end_x,
  input  spiw_pkg::coord_t seg_a_end_y,
  input  spiw_pkg::coord_t seg_b_start_x,
  input  spiw_pkg::coord_t seg_b_start_y,
  input  spiw_pkg::coord_t seg_b_end_x,
  input  spiw_pkg::coord_t seg_b_end_y,
  input  spiw_pkg::win_t   win,
  output spiw_pkg::dstage_t dout
);
  import spiw_pkg::*;

  typedef struct packed {
    coord_t [NRNG-1:0] lo;
    coord_t [NRNG-1:0] hi;
  } rng_t;

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a < b) ? b : a;
  endfunction

  logic v1, v2, v3, v4, v5, v6;

  // stage 1
  logic signed [DIF_W-1:0] a1_1, b1_1, a2_1, b2_1;
  coord_t pax1, pay1, pbx1, pby1;
  rng_t rng_n, rng1, rng2, rng3, rng4, rng5;
  logic signed [DIF_W-1:0] a1_n, b1_n, a2_n, b2_n;

  assign a1_n = DIF_W'(seg_a_end_y) - DIF_W'(seg_a_start_y);
  assign b1_n = DIF_W'(seg_a_start_x) - DIF_W'(seg_a_end_x);
  assign a2_n = DIF_W'(seg_b_end_y) - DIF_W'(seg_b_start_y);
  assign b2_n = DIF_W'(seg_b_start_x) - DIF_W'(seg_b_end_x);

  always_comb begin
    rng_n.lo[0] = cmin(seg_a_start_x, seg_a_end_x);
    rng_n.hi[0] = cmax(seg_a_start_x, seg_a_end_x);
    rng_n.lo[1] = cmin(seg_b_start_x, seg_b_end_x);
    rng_n.hi[1] = cmax(seg_b_start_x, seg_b_end_x);
    rng_n.lo[2] = cmin(win.c1x, win.c2x);
    rng_n.hi[2] = cmax(win.c1x, win.c2x);
    rng_n.lo[3] = cmin(seg_a_start_y, seg_a_end_y);
    rng_n.hi[3] = cmax(seg_a_start_y, seg_a_end_y);
    rng_n.lo[4] = cmin(seg_b_start_y, seg_b_end_y);
    rng_n.hi[4] = cmax(seg_b_start_y, seg_b_end_y);
    rng_n.lo[5] = cmin(win.c1y, win.c2y);
    rng_n.hi[5] = cmax(win.c1y, win.c2y);
  end

  // stage 2: products
  logic signed [DIF_W-1:0] a1_2, b1_2, a2_2, b2_2;
  logic signed [CW-1:0] m1_n, m2_n, m3_n, m4_n, m5_n, m6_n;
  logic signed [CW-1:0] m1, m2, m3, m4, m5, m6;
  assign m1_n = a1_1 * pax1;
  assign m2_n = b1_1 * pay1;
  assign m3_n = a2_1 * pbx1;
  assign m4_n = b2_1 * pby1;
  assign m5_n = a1_1 * b2_1;
  assign m6_n = a2_1 * b1_1;

  // stage 3: line constants and determinant
  logic signed [DIF_W-1:0] a1_3, b1_3, a2_3, b2_3;
  logic signed [CW-1:0] c1, c2, det3;

  // stage 4: numerator products
  logic signed [NW-1:0] p1_n, p2_n, p3_n, p4_n;
  logic signed [NW-1:0] p1, p2, p3, p4;
  logic signed [CW-1:0] det4;
  assign p1_n = b2_3 * c1;
  assign p2_n = b1_3 * c2;
  assign p3_n = a1_3 * c2;
  assign p4_n = a2_3 * c1;

  // stage 5: numerators, determinant magnitude
  logic signed [NW-1:0] nxr, nyr;
  logic [CW-1:0] dabs5, dabs6;
  logic neg5, nz5, nz6;

  // stage 6: sign-corrected numerators and bound products
  logic signed [NW-1:0] nx, ny;
  logic signed [NW-1:0] blo_n [NRNG];
  logic signed [NW-1:0] bhi_n [NRNG];
  logic signed [NW-1:0] blo [NRNG];
  logic signed [NW-1:0] bhi [NRNG];
  logic signed [CW:0]   dsg;
  assign dsg = $signed({1'b0, dabs5});

  always_comb begin
    for (int i = 0; i < NRNG; i++) begin
      blo_n[i] = $signed(rng5.lo[i]) * dsg;
      bhi_n[i] = $signed(rng5.hi[i]) * dsg;
    end
  end

  // stage 7: bounds tests and divider set-up
  logic                 hit_n;
  logic [NW-1:0]        magx, magy;
  logic [NW+FRAC_BITS-1:0] dvx, dvy;

  always_comb begin
    hit_n = nz6;
    for (int i = 0; i < NRNG; i++) begin
      if (i < NRNG / 2) begin
        if (blo[i] > nx || nx > bhi[i]) hit_n = 1'b0;
      end else begin
        if (blo[i] > ny || ny > bhi[i]) hit_n = 1'b0;
      end
    end
  end

  assign magx = nx[NW-1] ? NW'(-nx) : NW'(nx);
  assign magy = ny[NW-1] ? NW'(-ny) : NW'(ny);
  assign dvx  = (NW + FRAC_BITS)'(magx) << FRAC_BITS;
  assign dvy  = (NW + FRAC_BITS)'(magy) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      v5     <= 1'b0;
      v6     <= 1'b0;
      dout.v <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      v5     <= v4;
      v6     <= v5;
      dout.v <= v6;
    end

    if (en) begin
      a1_1 <= a1_n;
      b1_1 <= b1_n;
      a2_1 <= a2_n;
      b2_1 <= b2_n;
      pax1 <= seg_a_start_x;
      pay1 <= seg_a_start_y;
      pbx1 <= seg_b_start_x;
      pby1 <= seg_b_start_y;
      rng1 <= rng_n;

      a1_2 <= a1_1;
      b1_2 <= b1_1;
      a2_2 <= a2_1;
      b2_2 <= b2_1;
      m1   <= m1_n;
      m2   <= m2_n;
      m3   <= m3_n;
      m4   <= m4_n;
      m5   <= m5_n;
      m6   <= m6_n;
      rng2 <= rng1;

      a1_3 <= a1_2;
      b1_3 <= b1_2;
      a2_3 <= a2_2;
      b2_3 <= b2_2;
      c1   <= m1 + m2;
      c2   <= m3 + m4;
      det3 <= m5 - m6;
      rng3 <= rng2;

      p1   <= p1_n;
      p2   <= p2_n;
      p3   <= p3_n;
      p4   <= p4_n;
      det4 <= det3;
      rng4 <= rng3;

      nxr   <= p1 - p2;
      nyr   <= p3 - p4;
      neg5  <= det4[CW-1];
      nz5   <= (det4 != '0);
      dabs5 <= det4[CW-1] ? CW'(-det4) : CW'(det4);
      rng5  <= rng4;

      // flip numerators so the divisor is positive
      nx    <= neg5 ? -nxr : nxr;
      ny    <= neg5 ? -nyr : nyr;
      nz6   <= nz5;
      dabs6 <= dabs5;
      for (int i = 0; i < NRNG; i++) begin
        blo[i] <= blo_n[i];
        bhi[i] <= bhi_n[i];
      end

      dout.hit  <= hit_n;
      dout.negx <= nx[NW-1];
      dout.negy <= ny[NW-1];
      dout.dabs <= dabs6;
      dout.remx <= CW'(dvx >> QB);
      dout.remy <= CW'(dvy >> QB);
      dout.dqx  <= dvx[QB-1:0];
      dout.dqy  <= dvy[QB-1:0];
    end
  end

endmodule

>>> rtl/spiw_div.sv
// Pipelined restoring divider for both coordinates, DSTEPS quotient bits per stage.
// Takes dividends from spiw_geom; depends on spiw_pkg.
module spiw_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  spiw_pkg::dstage_t din,
  output spiw_pkg::dstage_t dout
);
  import spiw_pkg::*;

  // remainder and dividend/quotient register, shifted one bit per step
  function automatic logic [CW+QB-1:0] dstep(logic [CW-1:0] rem, logic [QB-1:0] dq,
                                             logic [CW-1:0] d);
    logic [CW:0] sh;
    logic [CW:0] tr;
    sh = {rem, dq[QB-1]};
    tr = sh - {1'b0, d};
    if (!tr[CW]) return {tr[CW-1:0], dq[QB-2:0], 1'b1};
    return {sh[CW-1:0], dq[QB-2:0], 1'b0};
  endfunction

  dstage_t st [DSTAGES+1];
  assign st[0] = din;
  assign dout  = st[DSTAGES];

  for (genvar s = 0; s < DSTAGES; s++) begin : g_stage
    dstage_t nxt;

    always_comb begin
      nxt = st[s];
      for (int k = 0; k < DSTEPS; k++) begin
        {nxt.remx, nxt.dqx} = dstep(nxt.remx, nxt.dqx, nxt.dabs);
        {nxt.remy, nxt.dqy} = dstep(nxt.remy, nxt.dqy, nxt.dabs);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) st[s+1].v <= 1'b0;
      else if (en) st[s+1] <= nxt;
    end
  end

endmodule

>>> rtl/spiw_out.sv
// Output register with a skid stage; signs the quotients and zeroes a miss.
// Drives the pipeline advance; depends on spiw_pkg.
module spiw_out (
  input  logic              clk,
  input  logic              rst,
  input  spiw_pkg::dstage_t p,
  output logic              en,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output spiw_pkg::out_t    cross_x,
  output spiw_pkg::out_t    cross_y
);
  import spiw_pkg::*;

  logic          sv;
  logic          s_hit;
  out_t          s_x, s_y;
  logic [QB-1:0] sx, sy;
  out_t          fx, fy;
  logic          o_free;

  assign sx     = p.negx ? -p.dqx : p.dqx;
  assign sy     = p.negy ? -p.dqy : p.dqy;
  assign fx     = p.hit ? out_t'($signed(sx)) : '0;
  assign fy     = p.hit ? out_t'($signed(sy)) : '0;
  assign o_free = !out_valid || out_ready;
  assign en     = !sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sv        <= 1'b0;
    end else if (o_free) begin
      out_valid <= sv | p.v;
      sv        <= 1'b0;
    end else if (!sv && p.v) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      if (sv) begin
        hit     <= s_hit;
        cross_x <= s_x;
        cross_y <= s_y;
      end else begin
        hit     <= p.v & p.hit;
        cross_x <= fx;
        cross_y <= fy;
      end
    end else if (!sv) begin
      // hold the transfer that the receiver stalled
      s_hit <= p.hit;
      s_x   <= fx;
      s_y   <= fy;
    end
  end

endmodule

>>> rtl/segment_pair_intersect_in_window.sv
// Top level of the segment pair intersection block: window registers and pipeline.
// Instantiates spiw_geom, spiw_div and spiw_out; depends on spiw_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries two segments as four endpoints.
//   Output channel (out_valid/out_ready) returns hit and the crossing point in
//   signed Q16.16, truncated toward zero; a miss returns hit 0 and zero point.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   window corners 0..3; cfg_ready is always high. Write only while idle.
// Timing:
//   One pair per cycle sustained while the receiver keeps out_ready high.
//   16 register stages: 7 for products, numerators and bounds, 8 divider
//   stages of 4 quotient bits each, and the output register. out_valid rises
//   when the result is loaded into the output register.
// Reset clears all valid bits and the window to zero.
// When the receiver stalls, one result moves into a skid register; in_ready
// then drops and the whole pipeline holds until the skid register drains.
module segment_pair_intersect_in_window (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  spiw_pkg::coord_t                 seg_a_start_x,
  input  spiw_pkg::coord_t                 seg_a_start_y,
  input  spiw_pkg::coord_t                 seg_a_end_x,
  input  spiw_pkg::coord_t                 seg_a_end_y,
  input  spiw_pkg::coord_t                 seg_b_start_x,
  input  spiw_pkg::coord_t                 seg_b_start_y,
  input  spiw_pkg::coord_t                 seg_b_end_x,
  input  spiw_pkg::coord_t                 seg_b_end_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output spiw_pkg::out_t                   cross_x,
  output spiw_pkg::out_t                   cross_y,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spiw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  spiw_pkg::coord_t                 cfg_data
);
  import spiw_pkg::*;

  win_t    win;
  dstage_t g2d, d2o;
  logic    en;

  assign cfg_ready = 1'b1;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1X: win.c1x <= cfg_data;
        REG_C1Y: win.c1y <= cfg_data;
        REG_C2X: win.c2x <= cfg_data;
        REG_C2Y: win.c2y <= cfg_data;
        default: ;
      endcase
    end
  end

  spiw_geom u_geom (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .seg_a_start_x (seg_a_start_x),
    .seg_a_start_y (seg_a_start_y),
    .seg_a_end_x   (seg_a_end_x),
    .seg_a_end_y   (seg_a_end_y),
    .seg_b_start_x (seg_b_start_x),
    .seg_b_start_y (seg_b_start_y),
    .seg_b_end_x   (seg_b_end_x),
    .seg_b_end_y   (seg_b_end_y),
    .win           (win),
    .dout          (g2d)
  );

  spiw_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (g2d),
    .dout (d2o)
  );

  spiw_out u_out (
    .clk       (clk),
    .rst       (rst),
    .p         (d2o),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
  );

endmodule
